### design/sjgc_pkg.sv
// ----------------------------------------------------------------------------
// sjgc_pkg
// Shared types and constants for the sequenced journal with gap count.
// ----------------------------------------------------------------------------
package sjgc_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W   = 9;
  localparam int SEQ_W    = 64;
  localparam int REV_W    = 32;
  localparam int STAT_W   = 3;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_INVALID   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_ORDER     = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_MARK   = 1'b1
  } mode_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic carry;
    logic zero;
  } alu_flags_t;

  typedef struct packed {
    logic             seq_en;
    logic             mark_en;
    logic [IDX_W-1:0] addr;
    logic [SEQ_W-1:0] seq;
    logic             mark;
  } store_wr_t;

endpackage

### design/sjgc_if.sv
// ----------------------------------------------------------------------------
// sjgc_if
// Valid/ready channels for the request and response words.
// ----------------------------------------------------------------------------
interface sjgc_in_if import sjgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [SEQ_W-1:0] seq_number;
  logic             fields_present;
  logic             initial_persisted;

  modport source (output valid, mode, seq_number, fields_present, initial_persisted,
                  input ready);
  modport sink   (input valid, mode, seq_number, fields_present, initial_persisted,
                  output ready);
endinterface

interface sjgc_out_if import sjgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SEQ_W-1:0]  gap_total;
  logic [FILL_W-1:0] entries_used;
  logic [FILL_W-1:0] persisted_total;
  logic [REV_W-1:0]  revision_number;

  modport source (output valid, status, gap_total, entries_used, persisted_total,
                  revision_number, input ready);
  modport sink   (input valid, status, gap_total, entries_used, persisted_total,
                  revision_number, output ready);
endinterface

### design/sjgc_alu.sv
// ----------------------------------------------------------------------------
// sjgc_alu
// Shared 64-bit add/subtract unit with carry and zero flags.
// ----------------------------------------------------------------------------
module sjgc_alu import sjgc_pkg::*; (
  input  alu_op_e          op_i,
  input  logic [SEQ_W-1:0] a_i,
  input  logic [SEQ_W-1:0] b_i,
  output logic [SEQ_W-1:0] res_o,
  output alu_flags_t       flags_o
);

  logic [SEQ_W-1:0] b_eff;
  logic [SEQ_W:0]   sum;
  logic             sub;

  assign sub   = (op_i == ALU_SUB);
  assign b_eff = b_i ^ {SEQ_W{sub}};
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + {{SEQ_W{1'b0}}, sub};

  // for subtract, carry set means a >= b
  assign res_o         = sum[SEQ_W-1:0];
  assign flags_o.carry = sum[SEQ_W];
  assign flags_o.zero  = (sum[SEQ_W-1:0] == '0);

endmodule

### design/sjgc_store.sv
// ----------------------------------------------------------------------------
// sjgc_store
// Entry table: sequence and persisted mark, one write and one registered read.
// ----------------------------------------------------------------------------
module sjgc_store import sjgc_pkg::*; (
  input  logic             clk_i,
  input  store_wr_t        wr_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [SEQ_W-1:0] rd_seq_o,
  output logic             rd_mark_o
);

  logic [SEQ_W-1:0] seq_mem [CAPACITY];
  logic             mark_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.seq_en) begin
      seq_mem[wr_i.addr] <= wr_i.seq;
    end
    if (wr_i.mark_en) begin
      mark_mem[wr_i.addr] <= wr_i.mark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_seq_o  <= seq_mem[rd_addr_i];
      rd_mark_o <= mark_mem[rd_addr_i];
    end
  end

endmodule

### design/sequenced_journal_with_gap_count_core.sv
// ----------------------------------------------------------------------------
// sequenced_journal_with_gap_count_core
// Journal of sequenced entries with gap, fill, persisted and revision counters.
//
//   port    dir  modport  word
//   req_i   in   sink     mode, seq_number, fields_present, initial_persisted
//   rsp_o   out  source   status, gap_total, entries_used, persisted_total,
//                         revision_number
//
// req_i.ready is high only while idle, so one word is in work at a time.
// Append: decode, then as needed the shared adder forms last+1, compares and
// adds the gap (S_EXP, S_CHK, S_GAP); mark: S_SRCH reads one entry per cycle.
// Each word returns to idle before the next is accepted.
// Reset clears control, fill, gap and tally, sets revision to 1; the table needs no clearing pass.
// A stalled rsp_o holds the result; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module sequenced_journal_with_gap_count_core import sjgc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sjgc_in_if.sink    req_i,
  sjgc_out_if.source rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_EXP  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_GAP  = 7'b0010000,
    S_SRCH = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic             mode_q, present_q, init_q;
  logic [SEQ_W-1:0] seq_q;
  logic [SEQ_W-1:0] last_q, last_d;
  logic [SEQ_W-1:0] exp_q, exp_d;
  logic [SEQ_W-1:0] diff_q, diff_d;
  logic [SEQ_W-1:0] gap_q, gap_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] tally_q, tally_d;
  logic [REV_W-1:0]  rev_q, rev_d;
  logic [FILL_W-1:0] rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  status_e           status_q, status_d;

  logic              out_vld_q, out_vld_d;
  logic              out_load;
  status_e           out_status_q;
  logic [SEQ_W-1:0]  out_gap_q;
  logic [FILL_W-1:0] out_fill_q, out_tally_q;
  logic [REV_W-1:0]  out_rev_q;

  logic             accept;
  logic             commit;
  alu_op_e          alu_op;
  logic [SEQ_W-1:0] alu_a, alu_b, alu_res;
  alu_flags_t       alu_flags;
  store_wr_t        wr;
  logic             rd_en;
  logic [SEQ_W-1:0] rd_seq;
  logic             rd_mark;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  sjgc_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  sjgc_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[IDX_W-1:0]),
    .rd_seq_o  (rd_seq),
    .rd_mark_o (rd_mark)
  );

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = seq_q;
    alu_b  = rd_seq;
    unique case (state_q)
      S_EXP: begin
        alu_op = ALU_ADD;
        alu_a  = last_q;
        alu_b  = {{(SEQ_W-1){1'b0}}, 1'b1};
      end
      S_CHK: begin
        alu_b = exp_q;
      end
      S_GAP: begin
        alu_op = ALU_ADD;
        alu_a  = gap_q;
        alu_b  = diff_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    exp_d     = exp_q;
    diff_d    = diff_q;
    gap_d     = gap_q;
    fill_d    = fill_q;
    tally_d   = tally_q;
    rev_d     = rev_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = rd_vld_q;
    cmp_idx_d = cmp_idx_q;
    status_d  = status_q;
    commit    = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    out_vld_d = out_vld_q;
    wr        = '0;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        rd_idx_d = '0;
        rd_vld_d = 1'b0;
        if (seq_q == '0 || (mode_q == MODE_APPEND && !present_q)) begin
          status_d = STATUS_INVALID;
          state_d  = S_FIN;
        end else if (mode_q == MODE_MARK) begin
          state_d = S_SRCH;
        end else if (fill_q >= FILL_W'(CAPACITY)) begin
          status_d = STATUS_FULL;
          state_d  = S_FIN;
        end else if (fill_q == '0) begin
          commit = 1'b1;
        end else begin
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        exp_d   = alu_res;
        state_d = S_CHK;
      end
      S_CHK: begin
        diff_d = alu_res;
        if (!alu_flags.carry) begin
          status_d = STATUS_ORDER;
          state_d  = S_FIN;
        end else if (alu_flags.zero) begin
          commit = 1'b1;
        end else begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        gap_d  = alu_res;
        commit = 1'b1;
      end
      S_SRCH: begin
        if (rd_vld_q && alu_flags.zero) begin
          wr.mark_en = 1'b1;
          wr.addr    = cmp_idx_q;
          wr.mark    = 1'b1;
          if (!rd_mark) begin
            tally_d = tally_q + {{(FILL_W-1){1'b0}}, 1'b1};
          end
          rev_d    = rev_q + {{(REV_W-1){1'b0}}, 1'b1};
          status_d = STATUS_OK;
          state_d  = S_FIN;
        end else if (rd_idx_q == fill_q) begin
          status_d = STATUS_NOT_FOUND;
          state_d  = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + {{(FILL_W-1){1'b0}}, 1'b1};
        end
      end
      S_FIN: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (commit) begin
      wr.seq_en  = 1'b1;
      wr.mark_en = 1'b1;
      wr.addr    = fill_q[IDX_W-1:0];
      wr.seq     = seq_q;
      wr.mark    = init_q;
      last_d     = seq_q;
      fill_d     = fill_q + {{(FILL_W-1){1'b0}}, 1'b1};
      tally_d    = tally_q + {{(FILL_W-1){1'b0}}, init_q};
      rev_d      = rev_q + {{(REV_W-1){1'b0}}, 1'b1};
      status_d   = STATUS_OK;
      state_d    = S_FIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      gap_q     <= '0;
      tally_q   <= '0;
      rev_q     <= {{(REV_W-1){1'b0}}, 1'b1};
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      gap_q     <= gap_d;
      tally_q   <= tally_d;
      rev_q     <= rev_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= req_i.mode;
      seq_q     <= req_i.seq_number;
      present_q <= req_i.fields_present;
      init_q    <= req_i.initial_persisted;
    end
    last_q    <= last_d;
    exp_q     <= exp_d;
    diff_q    <= diff_d;
    cmp_idx_q <= cmp_idx_d;
    status_q  <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_gap_q    <= gap_q;
      out_fill_q   <= fill_q;
      out_tally_q  <= tally_q;
      out_rev_q    <= rev_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.gap_total       = out_gap_q;
  assign rsp_o.entries_used    = out_fill_q;
  assign rsp_o.persisted_total = out_tally_q;
  assign rsp_o.revision_number = out_rev_q;

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(CAPACITY))
    else $error("fill level above capacity");

  a_tally_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= fill_q)
    else $error("persisted tally above fill level");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DEC)
    else $error("accepted word not decoded");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH && rd_vld_q) |-> ({1'b0, cmp_idx_q} < fill_q))
    else $error("search compares beyond stored entries");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ($past(state_q) != S_SRCH && $past(state_q) != S_IDLE))
    else $error("fill level changed outside append");

endmodule

### tb/tb_sequenced_journal_with_gap_count_core.sv
// ----------------------------------------------------------------------------
// tb_sequenced_journal_with_gap_count_core
// Self-checking bench for the sequenced journal: request words go in through
// the valid/ready request channel, a journal predictor computes the status
// and counters for each accepted word, and every response word is compared
// field by field in order. Directed checks cover rejects, ordering, gaps,
// sequence wrap, marking and a full table; random traffic runs under four
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_sequenced_journal_with_gap_count_core;
  import sjgc_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [SEQ_W-1:0]  gap_total;
    logic [FILL_W-1:0] entries_used;
    logic [FILL_W-1:0] persisted_total;
    logic [REV_W-1:0]  revision_number;
  } journal_result_t;

  logic clk_i;
  logic rst_ni;

  sjgc_in_if  req_if ();
  sjgc_out_if rsp_if ();

  sequenced_journal_with_gap_count_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // journal predictor state
  logic [SEQ_W-1:0]  journal_seq [CAPACITY];
  logic              journal_mark [CAPACITY];
  int                journal_fill;
  logic [SEQ_W-1:0]  journal_gap;
  int                journal_persisted;
  logic [REV_W-1:0]  journal_rev;

  journal_result_t   pending_results [$];
  int                failures;
  int                send_idle_pct;
  int                recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [SEQ_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SEQ_W-1:0] last_seq();
    return journal_seq[journal_fill-1];
  endfunction

  function automatic journal_result_t journal_apply(mode_e mode, logic [SEQ_W-1:0] seq,
                                                    bit present, bit init_mark);
    journal_result_t  res;
    logic [SEQ_W-1:0] next_seq;
    status_e          st;
    st = STATUS_OK;
    if (mode == MODE_APPEND) begin
      if (seq == '0 || !present) begin
        st = STATUS_INVALID;
      end else if (journal_fill >= CAPACITY) begin
        st = STATUS_FULL;
      end else begin
        next_seq = (journal_fill == 0) ? seq : last_seq() + 64'd1;
        if (seq < next_seq) begin
          st = STATUS_ORDER;
        end else begin
          journal_gap = journal_gap + (seq - next_seq);
          journal_seq[journal_fill]  = seq;
          journal_mark[journal_fill] = init_mark;
          if (init_mark) journal_persisted++;
          journal_fill++;
          journal_rev = journal_rev + 32'd1;
        end
      end
    end else begin
      if (seq == '0) begin
        st = STATUS_INVALID;
      end else begin
        st = STATUS_NOT_FOUND;
        for (int i = 0; i < journal_fill; i++) begin
          if (journal_seq[i] == seq) begin
            if (!journal_mark[i]) begin
              journal_mark[i] = 1'b1;
              journal_persisted++;
            end
            journal_rev = journal_rev + 32'd1;
            st = STATUS_OK;
            break;
          end
        end
      end
    end
    res.status          = st;
    res.gap_total       = journal_gap;
    res.entries_used    = journal_fill[FILL_W-1:0];
    res.persisted_total = journal_persisted[FILL_W-1:0];
    res.revision_number = journal_rev;
    return res;
  endfunction

  task automatic send_word(mode_e mode, logic [SEQ_W-1:0] seq, bit present, bit init_mark);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid             <= 1'b1;
    req_if.mode              <= mode;
    req_if.seq_number        <= seq;
    req_if.fields_present    <= present;
    req_if.initial_persisted <= init_mark;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(journal_apply(mode, seq, present, init_mark));
  endtask

  task automatic check_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // response side: random stall, in-order compare
  initial begin
    journal_result_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected response word, status %0d", rsp_if.status);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("gap_total", want.gap_total, rsp_if.gap_total);
          check_field("entries_used", want.entries_used, rsp_if.entries_used);
          check_field("persisted_total", want.persisted_total, rsp_if.persisted_total);
          check_field("revision_number", want.revision_number, rsp_if.revision_number);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_rejects_on_empty();
    send_word(MODE_APPEND, rand64(), 1'b0, 1'b1);
    send_word(MODE_APPEND, '0, 1'b1, 1'b1);
    send_word(MODE_MARK, '0, 1'b1, 1'b0);
    send_word(MODE_MARK, rand64(), 1'b0, 1'b0);
  endtask

  task automatic test_append_ordering(output logic [SEQ_W-1:0] base);
    base = rand64();
    base[SEQ_W-1:SEQ_W-2] = 2'b01;
    send_word(MODE_APPEND, base, 1'b1, 1'b1);
    send_word(MODE_APPEND, base + 64'd1, 1'b1, 1'b0);
    send_word(MODE_APPEND, base + 64'd1, 1'b1, 1'b0);
    send_word(MODE_APPEND, base - 64'd5, 1'b1, 1'b1);
    send_word(MODE_APPEND, base + 64'd10, 1'b1, 1'b1);
    send_word(MODE_APPEND, base + 64'd11, 1'b0, 1'b1);
    send_word(MODE_APPEND, '1, 1'b1, 1'b0);
    // next sequence after all-ones wraps to zero
    send_word(MODE_APPEND, 64'd7, 1'b1, 1'b0);
    send_word(MODE_APPEND, 64'd8, 1'b1, 1'b0);
  endtask

  task automatic test_mark_entries(logic [SEQ_W-1:0] base);
    send_word(MODE_MARK, base, 1'b0, 1'b0);
    send_word(MODE_MARK, base + 64'd1, 1'b1, 1'b1);
    send_word(MODE_MARK, base + 64'd1, 1'b0, 1'b0);
    send_word(MODE_MARK, '1, 1'b1, 1'b0);
    send_word(MODE_MARK, 64'd9, 1'b1, 1'b0);
    send_word(MODE_MARK, '0, 1'b1, 1'b1);
    send_word(MODE_MARK, 64'd8, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    int               pick;
    int               roll;
    logic [SEQ_W-1:0] seq;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      seq  = rand64();
      if (pick < 20) begin
        if (journal_fill > 0) begin
          roll = $urandom_range(99);
          if (roll < 70)      seq = last_seq() + 64'd1;
          else if (roll < 95) seq = last_seq() + 64'd1 + $urandom_range(1000, 1);
          else                seq = last_seq() + 64'd1 + (rand64() >> 8);
        end
        send_word(MODE_APPEND, seq, 1'b1, $urandom_range(1));
      end else if (pick < 58) begin
        if (journal_fill > 0) seq = journal_seq[$urandom_range(journal_fill-1)];
        send_word(MODE_MARK, seq, $urandom_range(1), $urandom_range(1));
      end else if (pick < 66) begin
        send_word(MODE_MARK, seq, $urandom_range(1), $urandom_range(1));
      end else if (pick < 74) begin
        send_word(MODE_APPEND, seq, 1'b0, $urandom_range(1));
      end else if (pick < 80) begin
        send_word(mode_e'($urandom_range(1)), '0, $urandom_range(1), $urandom_range(1));
      end else if (pick < 94) begin
        if (journal_fill > 0 && last_seq() != '0) seq = last_seq() - (seq % last_seq());
        send_word(MODE_APPEND, seq, 1'b1, $urandom_range(1));
      end else begin
        send_word(MODE_APPEND, seq, 1'b1, $urandom_range(1));
      end
    end
  endtask

  task automatic test_fill_table();
    while (journal_fill < CAPACITY) begin
      send_word(MODE_APPEND, last_seq() + 64'd1, 1'b1, $urandom_range(1));
    end
    send_word(MODE_APPEND, last_seq() + 64'd1, 1'b1, 1'b1);
    send_word(MODE_APPEND, '0, 1'b1, 1'b1);
    send_word(MODE_APPEND, last_seq() + 64'd1, 1'b0, 1'b0);
    send_word(MODE_MARK, journal_seq[CAPACITY-1], 1'b0, 1'b0);
    send_word(MODE_MARK, journal_seq[CAPACITY-1] + 64'd1, 1'b0, 1'b0);
  endtask

  initial begin
    logic [SEQ_W-1:0] base;
    failures          = 0;
    journal_fill      = 0;
    journal_gap       = '0;
    journal_persisted = 0;
    journal_rev       = 32'd1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;

    req_if.valid             <= 1'b0;
    req_if.mode              <= MODE_APPEND;
    req_if.seq_number        <= '0;
    req_if.fields_present    <= 1'b0;
    req_if.initial_persisted <= 1'b0;
    rst_ni                   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_rejects_on_empty();
    test_append_ordering(base);
    test_mark_entries(base);
    test_random_traffic(355, 0, 0);
    test_random_traffic(355, 56, 0);
    test_random_traffic(355, 0, 56);
    test_random_traffic(355, 11, 11);
    test_fill_table();

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
